>>> design/sart_pkg.sv
package sart_pkg;

   // Item kinds on the request channel
   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   // Response status codes
   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_HIT      = 2'd2;
   localparam logic [1:0] ST_MISS     = 2'd3;

   localparam int ADDR_W = 64;

   typedef struct packed {
      logic [ADDR_W-1:0] base_addr;
      logic [ADDR_W-1:0] last_addr;
   } entry_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] found_start;
      logic [ADDR_W-1:0] found_end;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_LK_RD,
      S_LK_CMP,
      S_DONE
   } state_type;

endpackage

>>> design/sorted_address_range_table_core.sv
// Insert: entries starting above the new start move up one slot (at most CAPACITY-1
// moved), then the new range is written. Lookup: binary search, at most log2(CAPACITY)+1
// probes, ending on a hit or when the search runs out. Lookup on an empty table or insert
// into a full one skips the table. One item at a time: the next request transfer is taken
// the cycle after the result moves out; a stalled response holds the sequencer. Reset
// clears entry count and handshake state only; table RAM is never cleared.
module sorted_address_range_table_core #(
   parameter int CAPACITY = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_action,
   input  logic [sart_pkg::ADDR_W-1:0] req_range_start,
   input  logic [sart_pkg::ADDR_W-1:0] req_range_end,
   input  logic [sart_pkg::ADDR_W-1:0] req_lookup_addr,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_status,
   output logic [sart_pkg::ADDR_W-1:0] rsp_found_start,
   output logic [sart_pkg::ADDR_W-1:0] rsp_found_end
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // table RAM: one entry per range, {start, end}, kept sorted by start
   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   sart_pkg::entry_type  mem_wr_data;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   sart_pkg::entry_type  mem_rd_data;

   // sequencer hands over a finished result
   logic                 res_valid;
   sart_pkg::result_type res;
   logic                 res_take;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   sart_pkg::result_type rsp_ff, rsp_in;

   sart_ram #(
      .WIDTH ($bits(sart_pkg::entry_type)),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   sart_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .action      (req_action),
      .range_start (req_range_start),
      .range_end   (req_range_end),
      .lookup_addr (req_lookup_addr),
      .res_valid   (res_valid),
      .res         (res),
      .res_take    (res_take),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // output register is free when empty or being drained this cycle
   assign res_take = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_found_start = rsp_ff.found_start;
   assign rsp_found_end   = rsp_ff.found_end;

endmodule

>>> design/sart_ram.sv
module sart_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/sart_ctrl.sv
module sart_ctrl #(
   parameter int CAPACITY = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   // request side
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            action,
   input  logic [sart_pkg::ADDR_W-1:0]     range_start,
   input  logic [sart_pkg::ADDR_W-1:0]     range_end,
   input  logic [sart_pkg::ADDR_W-1:0]     lookup_addr,
   // finished result, handed to the output register
   output logic                            res_valid,
   output sart_pkg::result_type            res,
   input  logic                            res_take,
   // table memory
   output logic                            mem_wr_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_wr_addr,
   output sart_pkg::entry_type             mem_wr_data,
   output logic                            mem_rd_en,
   output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] mem_rd_addr,
   input  sart_pkg::entry_type             mem_rd_data
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   sart_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     pos_ff, pos_in;
   logic [CNT_W-1:0]     lo_ff, lo_in;
   logic [CNT_W-1:0]     hi_ff, hi_in;
   logic [IDX_W-1:0]     mid_ff, mid_in;
   logic [sart_pkg::ADDR_W-1:0] key_start_ff, key_start_in;
   logic [sart_pkg::ADDR_W-1:0] key_end_ff, key_end_in;
   logic [sart_pkg::ADDR_W-1:0] key_addr_ff, key_addr_in;
   sart_pkg::result_type res_ff, res_in;

   logic             accept;
   logic             full;
   logic [CNT_W:0]   mid_sum;
   logic [CNT_W-1:0] mid_full;
   logic [CNT_W-1:0] pos_dec;
   logic             probe_hit;
   logic             probe_below;

   assign accept      = req_valid && (state_ff == sart_pkg::S_IDLE);
   assign full        = (count_ff == CNT_W'(CAPACITY));
   assign mid_sum     = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_full    = mid_sum[CNT_W:1];
   assign pos_dec     = pos_ff - 1'b1;
   assign probe_below = (key_addr_ff < mem_rd_data.base_addr);
   assign probe_hit   = !probe_below && (key_addr_ff <= mem_rd_data.last_addr);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sart_pkg::S_IDLE: begin
            if (accept) begin
               if (action == sart_pkg::ACT_INSERT) begin
                  state_in = full ? sart_pkg::S_DONE : sart_pkg::S_INS_RD;
               end else begin
                  state_in = (count_ff == '0) ? sart_pkg::S_DONE : sart_pkg::S_LK_RD;
               end
            end
         end
         sart_pkg::S_INS_RD: begin
            state_in = (pos_ff == '0) ? sart_pkg::S_DONE : sart_pkg::S_INS_CMP;
         end
         sart_pkg::S_INS_CMP: begin
            state_in = (mem_rd_data.base_addr > key_start_ff) ? sart_pkg::S_INS_RD
                                                              : sart_pkg::S_DONE;
         end
         sart_pkg::S_LK_RD: begin
            state_in = (lo_ff > hi_ff) ? sart_pkg::S_DONE : sart_pkg::S_LK_CMP;
         end
         sart_pkg::S_LK_CMP: begin
            if (probe_hit || (probe_below && mid_ff == '0)) begin
               state_in = sart_pkg::S_DONE;
            end else begin
               state_in = sart_pkg::S_LK_RD;
            end
         end
         sart_pkg::S_DONE: begin
            if (res_take) begin
               state_in = sart_pkg::S_IDLE;
            end
         end
         default: state_in = sart_pkg::S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_start_in = key_start_ff;
      key_end_in   = key_end_ff;
      key_addr_in  = key_addr_ff;
      res_in       = res_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = pos_ff[IDX_W-1:0];
      mem_wr_data  = mem_rd_data;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = pos_dec[IDX_W-1:0];
      unique case (state_ff)
         sart_pkg::S_IDLE: begin
            if (accept) begin
               key_start_in = range_start;
               key_end_in   = range_end;
               key_addr_in  = lookup_addr;
               res_in       = '0;
               if (action == sart_pkg::ACT_INSERT) begin
                  if (full) begin
                     res_in.status = sart_pkg::ST_FULL;
                  end else begin
                     pos_in   = count_ff;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  res_in.status = sart_pkg::ST_MISS;
                  lo_in         = '0;
                  hi_in         = count_ff - 1'b1;
               end
            end
         end
         sart_pkg::S_INS_RD: begin
            // at the bottom: drop the new range in place
            if (pos_ff == '0) begin
               mem_wr_en             = 1'b1;
               mem_wr_data.base_addr = key_start_ff;
               mem_wr_data.last_addr = key_end_ff;
               res_in.status         = sart_pkg::ST_INSERTED;
            end else begin
               mem_rd_en = 1'b1;
            end
         end
         sart_pkg::S_INS_CMP: begin
            mem_wr_en = 1'b1;
            if (mem_rd_data.base_addr > key_start_ff) begin
               // neighbor moves up one slot
               pos_in = pos_dec;
            end else begin
               mem_wr_data.base_addr = key_start_ff;
               mem_wr_data.last_addr = key_end_ff;
               res_in.status         = sart_pkg::ST_INSERTED;
            end
         end
         sart_pkg::S_LK_RD: begin
            if (lo_ff <= hi_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = mid_full[IDX_W-1:0];
               mid_in      = mid_full[IDX_W-1:0];
            end
         end
         sart_pkg::S_LK_CMP: begin
            if (probe_hit) begin
               res_in.status      = sart_pkg::ST_HIT;
               res_in.found_start = mem_rd_data.base_addr;
               res_in.found_end   = mem_rd_data.last_addr;
            end else if (probe_below) begin
               hi_in = CNT_W'(mid_ff) - 1'b1;
            end else begin
               lo_in = CNT_W'(mid_ff) + 1'b1;
            end
         end
         sart_pkg::S_DONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sart_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_start_ff <= key_start_in;
      key_end_ff   <= key_end_in;
      key_addr_ff  <= key_addr_in;
      res_ff       <= res_in;
   end

   assign req_stall = (state_ff != sart_pkg::S_IDLE);
   assign res_valid = (state_ff == sart_pkg::S_DONE);
   assign res       = res_ff;

endmodule
